// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define FN_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define FN_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/fnorm_pkg.sv
// Shared types and constants of the fraction normalizer.
package fnorm_pkg;

   localparam int unsigned DataW = 32;
   localparam int unsigned DenW  = 31;
   localparam int unsigned UnitW = DataW + 1;
   localparam int unsigned CntW  = 5;

   localparam logic [CntW-1:0] DIV_LAST = CntW'(DataW - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } fnorm_state_type;

   typedef struct packed {
      logic             ge;
      logic [UnitW-1:0] diff;
   } fnorm_sub_type;

endpackage

// File: rtl/fraction_normalizer_unit.sv
// Top level of the fraction normalizer: reduces a signed fraction to lowest terms.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_tvalid/tready     tdata[31:0] num_in, [63:32] den_in
//   rsp       out        rsp_tvalid/tready     tdata[31:0] num_out, [62:32] den_out
//
// One request is worked on at a time; req_tready is high only while the sequencer is idle.
// A zero numerator goes straight from acceptance to the done state. Otherwise a binary GCD
// loop runs one step per cycle through the shared subtractor, then two restoring divisions
// reuse the same unit, first for the numerator and then for the denominator.
// The result register lets a finished result wait on rsp_tready while the unit is idle.
// Reset is synchronous and active high; it clears the sequencer and the output valid.
`include "assert_macros.svh"

module fraction_normalizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] num_in, [63:32] den_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata    // [31:0] num_out, [62:32] den_out, [63] zero
);
   import fnorm_pkg::*;

   fnorm_state_type state_ff, state_in;

   // Magnitudes of the normalized fraction and the sign of the result.
   logic [DataW-1:0] mag_ff, mag_in;
   logic [DataW-1:0] dmag_ff, dmag_in;
   logic             neg_ff, neg_in;

   // Binary GCD operands and the count of shared factors of two.
   logic [DataW-1:0] a_ff, a_in;
   logic [DataW-1:0] b_ff, b_in;
   logic [CntW-1:0]  k_ff, k_in;
   logic [DataW-1:0] g_ff, g_in;

   // Restoring divider: partial remainder, dividend/quotient shifter, step count.
   logic [DataW-1:0] rem_ff, rem_in;
   logic [DataW-1:0] quo_ff, quo_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   // Finished result and the output register.
   logic [DataW-1:0] qn_ff, qn_in;
   logic [DenW-1:0]  qd_ff, qd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0] rsp_num_ff, rsp_num_in;
   logic [DenW-1:0]  rsp_den_ff, rsp_den_in;

   logic [UnitW-1:0] unit_x, unit_y;
   fnorm_sub_type    unit_res;

   logic             req_accept;
   logic [DataW-1:0] req_num, req_den;
   logic             req_num_zero;
   logic             out_free;
   logic             div_last;
   logic [DataW-1:0] rem_next;
   logic [DataW-1:0] q_next;

   // Sequencer phases watched by the checks at the end.
   logic             in_gcd;
   logic             in_div;
   logic             div_end;

   fnorm_sub u_sub (
      .x   (unit_x),
      .y   (unit_y),
      .res (unit_res)
   );

   assign req_accept   = req_tvalid & req_tready;
   assign req_num      = req_tdata[DataW-1:0];
   assign req_den      = req_tdata[2*DataW-1:DataW];
   assign req_num_zero = (req_num == '0);
   assign out_free     = ~rsp_valid_ff | rsp_tready;
   assign div_last     = (cnt_ff == DIV_LAST);

   assign in_gcd  = (state_ff == ST_GCD);
   assign in_div  = (state_ff == ST_DIVN) | (state_ff == ST_DIVD);
   assign div_end = in_div & div_last;

   // One restoring division step: keep the difference when the trial value fits.
   assign rem_next = unit_res.ge ? unit_res.diff[DataW-1:0] : unit_x[DataW-1:0];
   assign q_next   = {quo_ff[DataW-2:0], unit_res.ge};

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = req_num_zero ? ST_DONE : ST_GCD;
            end
         end
         ST_GCD: begin
            if (b_ff == '0) begin
               state_in = ST_DIVN;
            end
         end
         ST_DIVN: begin
            if (div_last) begin
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: request ready and the operands of the shared unit.
   always_comb begin
      req_tready = 1'b0;
      unit_x     = '0;
      unit_y     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_GCD: begin
            unit_x = {1'b0, a_ff};
            unit_y = {1'b0, b_ff};
         end
         ST_DIVN, ST_DIVD: begin
            unit_x = {rem_ff, quo_ff[DataW-1]};
            unit_y = {1'b0, g_ff};
         end
         ST_DONE: begin
            req_tready = 1'b0;
         end
         default: req_tready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      mag_in       = mag_ff;
      dmag_in      = dmag_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      qn_in        = qn_ff;
      qd_in        = qd_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // Flipping both signs for a negative denominator leaves the result sign
               // as the exclusive or of the two input signs.
               neg_in  = req_num[DataW-1] ^ req_den[DataW-1];
               mag_in  = req_num[DataW-1] ? (~req_num + 1'b1) : req_num;
               dmag_in = req_den[DataW-1] ? (~req_den + 1'b1) : req_den;
               a_in    = req_num[DataW-1] ? (~req_num + 1'b1) : req_num;
               b_in    = req_den[DataW-1] ? (~req_den + 1'b1) : req_den;
               k_in    = '0;
               qn_in   = '0;
               qd_in   = DenW'(1);
            end
         end
         ST_GCD: begin
            priority if (b_ff == '0) begin
               g_in   = a_ff << k_ff;
               rem_in = '0;
               quo_in = mag_ff;
               cnt_in = '0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (unit_res.ge) begin
               a_in = b_ff;
               b_in = unit_res.diff[DataW-1:0];
            end else begin
               // Swap so that the next subtraction takes the smaller from the larger.
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         ST_DIVN: begin
            if (div_last) begin
               qn_in  = neg_ff ? (~q_next + 1'b1) : q_next;
               rem_in = '0;
               quo_in = dmag_ff;
               cnt_in = '0;
            end else begin
               rem_in = rem_next;
               quo_in = q_next;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DIVD: begin
            rem_in = rem_next;
            quo_in = q_next;
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               qd_in = q_next[DenW-1:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = qn_ff;
               rsp_den_in   = qd_ff;
            end
         end
         default: rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      dmag_ff    <= dmag_in;
      neg_ff     <= neg_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      qn_ff      <= qn_in;
      qd_ff      <= qd_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_den_ff, rsp_num_ff};

   // The GCD loop keeps a nonzero operand in a, since the numerator is nonzero there.
   `FN_ASSERT_RST(a_nonzero_in_gcd, clock, reset, in_gcd |-> (a_ff != '0), "gcd operand is zero")
   // Both divisions run with a nonzero divisor.
   `FN_ASSERT_RST(divisor_nonzero, clock, reset, in_div |-> (g_ff != '0), "divisor is zero")
   // The divisor is a common divisor, so each division ends with no remainder.
   `FN_ASSERT_RST(exact_div, clock, reset, div_end |-> (rem_next == '0), "remainder not zero")

endmodule

// File: rtl/fnorm_sub.sv
// Shared subtract and compare unit used by the GCD loop and the divider.
module fnorm_sub (
   input  logic [fnorm_pkg::UnitW-1:0] x,
   input  logic [fnorm_pkg::UnitW-1:0] y,
   output fnorm_pkg::fnorm_sub_type    res
);
   import fnorm_pkg::*;

   logic [UnitW:0] wide;

   // The extra top bit is the borrow; no borrow means x >= y.
   assign wide     = {1'b0, x} - {1'b0, y};
   assign res.diff = wide[UnitW-1:0];
   assign res.ge   = ~wide[UnitW];

endmodule
